// ===== src/esc_pkg.sv =====
// Shared types, constants, month table and microprogram for the epoch-to-calendar core.
`default_nettype none

package esc_pkg;

  localparam int unsigned PC_W    = 4;
  localparam int unsigned ACC_W   = 32;
  localparam int unsigned PROD_W  = 2 * ACC_W;
  localparam int unsigned SH_W    = 6;
  localparam int unsigned REM_W   = 11;  // holds a remainder below 1461
  localparam int unsigned DAYS_W  = 16;

  localparam logic [REM_W-1:0] DAYS_PER_CYCLE = 11'd1461;
  localparam logic [REM_W-1:0] DAYS_LEAP_YEAR = 11'd366;
  localparam logic [REM_W-1:0] DAYS_NORM_YEAR = 11'd365;
  localparam logic [ACC_W-1:0] EPOCH_WEEKDAY  = 32'd6;
  localparam logic [1:0]       LEAP_MASK      = 2'b11;
  localparam logic [3:0]       LAST_MONTH     = 4'd12;

  typedef enum logic [2:0] {
    OP_DIV,         // divide acc by a constant: reciprocal multiply, then remainder
    OP_SAVE_DAYS,   // days <= acc, acc <= acc + epoch weekday
    OP_LOAD_DAYS,   // acc <= days
    OP_YEAR_INIT,   // year <= 4 * cycles, month <= 1
    OP_YEAR_STEP,   // strip a year while the day count allows
    OP_MONTH_STEP,  // strip a month while the day count allows
    OP_DONE
  } op_t;

  typedef enum logic [1:0] {
    DV_60,
    DV_24,
    DV_7,
    DV_1461
  } div_t;

  typedef enum logic [2:0] {
    DST_SEC,
    DST_MIN,
    DST_HOUR,
    DST_WDAY,
    DST_TDAY
  } dst_t;

  typedef struct packed {
    op_t             op;
    div_t            dsel;
    dst_t            dst;
    logic [PC_W-1:0] jmp;
  } uword_t;

  localparam logic [PC_W-1:0] PC_YEAR  = 4'd8;
  localparam logic [PC_W-1:0] PC_MONTH = 4'd9;
  localparam logic [PC_W-1:0] PC_LAST  = 4'd10;

  function automatic logic [REM_W-1:0] divisor(input div_t d);
    case (d)
      DV_60:   divisor = 11'd60;
      DV_24:   divisor = 11'd24;
      DV_7:    divisor = 11'd7;
      DV_1461: divisor = DAYS_PER_CYCLE;
      default: divisor = 11'd60;
    endcase
  endfunction

  // (x * recip) >> rshift is the exact floor over each step's input range:
  // any 32-bit count for 60 and 24, day counts below 2^16 for 7 and 1461
  function automatic logic [ACC_W-1:0] recip(input div_t d);
    case (d)
      DV_60:   recip = 32'h8888_8889;
      DV_24:   recip = 32'hAAAA_AAAB;
      DV_7:    recip = 32'd74899;
      DV_1461: recip = 32'd45934;
      default: recip = 32'h8888_8889;
    endcase
  endfunction

  function automatic logic [SH_W-1:0] rshift(input div_t d);
    case (d)
      DV_60:   rshift = 6'd37;
      DV_24:   rshift = 6'd36;
      DV_7:    rshift = 6'd19;
      DV_1461: rshift = 6'd26;
      default: rshift = 6'd37;
    endcase
  endfunction

  function automatic logic [4:0] month_length(input logic [3:0] month, input logic leap);
    if (month == 4'd2) begin
      month_length = leap ? 5'd29 : 5'd28;
    end else if (month < 4'd8) begin
      month_length = month[0] ? 5'd31 : 5'd30;
    end else begin
      month_length = month[0] ? 5'd30 : 5'd31;
    end
  endfunction

  // Microprogram: one control word per step.
  function automatic uword_t ucode(input logic [PC_W-1:0] pc);
    uword_t w;
    w = '{op: OP_DONE, dsel: DV_60, dst: DST_SEC, jmp: '0};
    case (pc)
      4'd0:    w = '{op: OP_DIV,        dsel: DV_60,   dst: DST_SEC,  jmp: '0};
      4'd1:    w = '{op: OP_DIV,        dsel: DV_60,   dst: DST_MIN,  jmp: '0};
      4'd2:    w = '{op: OP_DIV,        dsel: DV_24,   dst: DST_HOUR, jmp: '0};
      4'd3:    w = '{op: OP_SAVE_DAYS,  dsel: DV_60,   dst: DST_SEC,  jmp: '0};
      4'd4:    w = '{op: OP_DIV,        dsel: DV_7,    dst: DST_WDAY, jmp: '0};
      4'd5:    w = '{op: OP_LOAD_DAYS,  dsel: DV_60,   dst: DST_SEC,  jmp: '0};
      4'd6:    w = '{op: OP_DIV,        dsel: DV_1461, dst: DST_TDAY, jmp: '0};
      4'd7:    w = '{op: OP_YEAR_INIT,  dsel: DV_60,   dst: DST_SEC,  jmp: '0};
      4'd8:    w = '{op: OP_YEAR_STEP,  dsel: DV_60,   dst: DST_SEC,  jmp: PC_YEAR};
      4'd9:    w = '{op: OP_MONTH_STEP, dsel: DV_60,   dst: DST_SEC,  jmp: PC_MONTH};
      4'd10:   w = '{op: OP_DONE,       dsel: DV_60,   dst: DST_SEC,  jmp: '0};
      default: w = '{op: OP_DONE,       dsel: DV_60,   dst: DST_SEC,  jmp: '0};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ===== src/epoch_seconds_to_calendar_core.sv =====
// Top level: microcoded converter from epoch seconds to calendar fields.
// The microprogram runs fixed steps (five reciprocal divides and three moves),
// then 1 to 4 year steps,
// 1 to 12 month steps and the final step.
// One conversion at a time; busy falls in the cycle done is high.
// Sync reset clears busy, the step counter and done; results have no reset.
`default_nettype none

module epoch_seconds_to_calendar_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [31:0] seconds_count,
  output logic             done,
  output logic [5:0]       second_of_minute,
  output logic [5:0]       minute_of_hour,
  output logic [4:0]       hour_of_day,
  output logic [2:0]       weekday,
  output logic [4:0]       day_of_month,
  output logic [3:0]       month_number,
  output logic [7:0]       year_offset
);

  logic [esc_pkg::PC_W-1:0]   pc;
  logic                       div_ph;
  logic [esc_pkg::ACC_W-1:0]  acc;
  logic [esc_pkg::ACC_W-1:0]  quo;
  logic [esc_pkg::DAYS_W-1:0] days;
  logic [esc_pkg::REM_W-1:0]  tday;
  logic                       first_year;

  logic [5:0] sec;
  logic [5:0] min;
  logic [4:0] hour;
  logic [2:0] wday;
  logic [7:0] year;
  logic [3:0] month;

  esc_pkg::uword_t            uw;
  logic [esc_pkg::REM_W-1:0]  dv;
  logic [esc_pkg::PROD_W-1:0] prod;
  logic [esc_pkg::ACC_W-1:0]  quo_next;
  logic [esc_pkg::REM_W-1:0]  rem_val;
  logic [esc_pkg::REM_W-1:0]  ylen;
  logic [4:0]                 mlen;
  logic                       year_go;
  logic                       month_go;
  logic                       accept;

  assign accept = start && !busy;
  assign uw     = esc_pkg::ucode(pc);

  // divide by a constant: quotient in the first phase, remainder in the second
  always_comb begin
    dv       = esc_pkg::divisor(uw.dsel);
    prod     = esc_pkg::PROD_W'(acc) * esc_pkg::PROD_W'(esc_pkg::recip(uw.dsel));
    quo_next = esc_pkg::ACC_W'(prod >> esc_pkg::rshift(uw.dsel));
    rem_val  = esc_pkg::REM_W'(acc - quo * esc_pkg::ACC_W'(dv));
  end

  always_comb begin
    ylen     = first_year ? esc_pkg::DAYS_LEAP_YEAR : esc_pkg::DAYS_NORM_YEAR;
    mlen     = esc_pkg::month_length(month, (year[1:0] & esc_pkg::LEAP_MASK) == 2'b00);
    year_go  = (tday >= ylen);
    month_go = (tday >= {6'd0, mlen}) && (month != esc_pkg::LAST_MONTH);
  end

  // sequencer control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      pc     <= '0;
      div_ph <= 1'b0;
      done   <= 1'b0;
    end else begin
      done <= busy && (uw.op == esc_pkg::OP_DONE);
      if (accept) begin
        busy   <= 1'b1;
        pc     <= '0;
        div_ph <= 1'b0;
      end else if (busy) begin
        case (uw.op)
          esc_pkg::OP_DIV: begin
            div_ph <= !div_ph;
            if (div_ph) begin
              pc <= esc_pkg::PC_W'(pc + 1'b1);
            end
          end
          esc_pkg::OP_YEAR_STEP: begin
            pc <= year_go ? uw.jmp : esc_pkg::PC_W'(pc + 1'b1);
          end
          esc_pkg::OP_MONTH_STEP: begin
            pc <= month_go ? uw.jmp : esc_pkg::PC_W'(pc + 1'b1);
          end
          esc_pkg::OP_DONE: begin
            busy <= 1'b0;
            pc   <= '0;
          end
          default: begin
            pc <= esc_pkg::PC_W'(pc + 1'b1);
          end
        endcase
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      acc <= seconds_count;
    end else if (busy) begin
      case (uw.op)
        esc_pkg::OP_DIV: begin
          if (!div_ph) begin
            quo <= quo_next;
          end else begin
            acc <= quo;
            case (uw.dst)
              esc_pkg::DST_SEC:  sec  <= rem_val[5:0];
              esc_pkg::DST_MIN:  min  <= rem_val[5:0];
              esc_pkg::DST_HOUR: hour <= rem_val[4:0];
              esc_pkg::DST_WDAY: wday <= rem_val[2:0];
              esc_pkg::DST_TDAY: tday <= rem_val;
              default:           sec  <= rem_val[5:0];
            endcase
          end
        end
        esc_pkg::OP_SAVE_DAYS: begin
          days <= acc[esc_pkg::DAYS_W-1:0];
          acc  <= acc + esc_pkg::EPOCH_WEEKDAY;
        end
        esc_pkg::OP_LOAD_DAYS: begin
          acc <= {{(esc_pkg::ACC_W-esc_pkg::DAYS_W){1'b0}}, days};
        end
        esc_pkg::OP_YEAR_INIT: begin
          // quotient of days by 1461 is at most 34
          year       <= {acc[5:0], 2'b00};
          first_year <= 1'b1;
          month      <= 4'd1;
        end
        esc_pkg::OP_YEAR_STEP: begin
          if (year_go) begin
            tday       <= tday - ylen;
            year       <= 8'(year + 1'b1);
            first_year <= 1'b0;
          end
        end
        esc_pkg::OP_MONTH_STEP: begin
          if (month_go) begin
            tday  <= tday - {6'd0, mlen};
            month <= 4'(month + 1'b1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign second_of_minute = sec;
  assign minute_of_hour   = min;
  assign hour_of_day      = hour;
  assign weekday          = wday;
  assign day_of_month     = 5'(tday[4:0] + 1'b1);
  assign month_number     = month;
  assign year_offset      = year;

  // busy is already low whenever the done strobe is high
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("done strobe while still busy");

  a_start_seq: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy && pc == '0))
    else $error("accepted beat did not restart the microprogram");

  a_pc_range: assert property (@(posedge clk) disable iff (rst) pc <= esc_pkg::PC_LAST)
    else $error("step counter ran past the program");

  a_fields: assert property (@(posedge clk) disable iff (rst)
    done |-> (month_number >= 4'd1 && month_number <= 4'd12 && day_of_month != 5'd0 &&
              weekday <= 3'd6 && hour_of_day <= 5'd23))
    else $error("calendar field out of range");

  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done held for more than one cycle");

endmodule

`default_nettype wire
